### rtl/cce_pkg.sv
// Package for the cubic curve evaluator: widths, payload structs,
// stage enables and the doubled basis coefficient table. No dependencies.
`default_nettype none

package cce_pkg;

  localparam int unsigned VALUE_WIDTH = 24;
  localparam int unsigned T_FRAC_BITS = 16;
  localparam int unsigned T_WIDTH     = T_FRAC_BITS + 1;
  localparam int unsigned P2_WIDTH    = T_FRAC_BITS + 2;
  localparam int unsigned P3_WIDTH    = T_FRAC_BITS + 3;
  // |doubled weight| < 108 * 2^F, so F+8 bits signed is enough
  localparam int unsigned W_WIDTH     = T_FRAC_BITS + 8;
  localparam int unsigned LO_WIDTH    = VALUE_WIDTH / 2;
  localparam int unsigned HI_WIDTH    = VALUE_WIDTH - LO_WIDTH;
  localparam int unsigned PROD_WIDTH  = W_WIDTH + VALUE_WIDTH;
  localparam int unsigned SUM_WIDTH   = PROD_WIDTH + 2;
  localparam int unsigned OUT_WIDTH   = VALUE_WIDTH + 2;
  localparam int unsigned NUM_CTRL    = 4;
  localparam int unsigned NUM_BASES   = 5;
  localparam int unsigned NUM_STAGES  = 7;

  typedef enum logic [2:0] {
    CMD_HERMITE  = 3'd0,
    CMD_BEZIER   = 3'd1,
    CMD_CATMULL  = 3'd2,
    CMD_CR_START = 3'd3,
    CMD_CR_END   = 3'd4
  } cmd_e;

  typedef logic signed [4:0]             coef_t;
  typedef logic signed [VALUE_WIDTH-1:0] ctrl_t;
  typedef logic signed [W_WIDTH-1:0]     weight_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  typedef struct packed {
    logic [2:0]                   command;
    logic [T_WIDTH-1:0]           param_t;
    logic signed [VALUE_WIDTH-1:0] ctrl_a;
    logic signed [VALUE_WIDTH-1:0] ctrl_b;
    logic signed [VALUE_WIDTH-1:0] ctrl_c;
    logic signed [VALUE_WIDTH-1:0] ctrl_d;
  } cce_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] curve_value;
    logic                        saturated;
  } cce_out_t;

  // Load enables, one per register stage
  typedef struct packed {
    logic sq;
    logic cube;
    logic wt;
    logic part;
    logic prod;
    logic sum;
    logic out;
  } pipe_en_t;

  // Doubled coefficients [basis][row][control]; rows are t^3, t^2, t, 1
  localparam coef_t BASIS2 [NUM_BASES][4][4] = '{
    '{ '{ 4, -4,  2,  2}, '{-6,   6, -4, -2}, '{ 0,  0,  2,  0}, '{2, 0, 0, 0} },
    '{ '{-2,  6, -6,  2}, '{ 6, -12,  6,  0}, '{-6,  6,  0,  0}, '{2, 0, 0, 0} },
    '{ '{-1,  3, -3,  1}, '{ 2,  -5,  4, -1}, '{-1,  0,  1,  0}, '{0, 2, 0, 0} },
    '{ '{ 0,  0,  0,  0}, '{ 0,   1, -2,  1}, '{ 0, -3,  4, -1}, '{0, 2, 0, 0} },
    '{ '{ 0,  0,  0,  0}, '{ 1,  -2,  1,  0}, '{-1,  0,  1,  0}, '{0, 2, 0, 0} }
  };

  // Unknown commands get all-zero weights, which yields a zero result
  function automatic coef_t basis_coef(logic [2:0] cmd, logic [1:0] row, logic [1:0] col);
    coef_t c;
    c = '0;
    if (cmd <= CMD_CR_END) begin
      c = BASIS2[cmd][row][col];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/cce_powers.sv
// Power stages of the cubic curve evaluator: t^2 and t^3 with rounding,
// two register stages. Depends on cce_pkg.
`default_nettype none

module cce_powers import cce_pkg::*; (
  input  wire logic            clk_i,
  input  pipe_en_t             en_i,
  input  cce_in_t              in_data_i,
  output logic [2:0]           cmd_o,
  output logic [T_WIDTH-1:0]   p1_o,
  output logic [P2_WIDTH-1:0]  p2_o,
  output logic [P3_WIDTH-1:0]  p3_o,
  output ctrl_t                ctrl_o [NUM_CTRL]
);

  localparam int unsigned SQ_WIDTH = 2 * T_WIDTH;
  localparam int unsigned CU_WIDTH = P2_WIDTH + T_WIDTH;
  localparam logic [SQ_WIDTH-1:0] SQ_HALF = SQ_WIDTH'(1) << (T_FRAC_BITS - 1);
  localparam logic [CU_WIDTH-1:0] CU_HALF = CU_WIDTH'(1) << (T_FRAC_BITS - 1);

  logic [SQ_WIDTH-1:0] sq_d, sq_q;
  logic [T_WIDTH-1:0]  t1_q, t2_q;
  logic [2:0]          cmd1_q, cmd2_q;
  ctrl_t               ctrl1_q [NUM_CTRL];
  ctrl_t               ctrl2_q [NUM_CTRL];
  logic [P2_WIDTH-1:0] p2_d, p2_q;
  logic [CU_WIDTH-1:0] cu_d, cu_q;

  assign sq_d = SQ_WIDTH'(in_data_i.param_t) * SQ_WIDTH'(in_data_i.param_t) + SQ_HALF;

  always_ff @(posedge clk_i) begin
    if (en_i.sq) begin
      sq_q       <= sq_d;
      t1_q       <= in_data_i.param_t;
      cmd1_q     <= in_data_i.command;
      ctrl1_q[0] <= in_data_i.ctrl_a;
      ctrl1_q[1] <= in_data_i.ctrl_b;
      ctrl1_q[2] <= in_data_i.ctrl_c;
      ctrl1_q[3] <= in_data_i.ctrl_d;
    end
  end

  assign p2_d = sq_q[T_FRAC_BITS +: P2_WIDTH];
  assign cu_d = CU_WIDTH'(p2_d) * CU_WIDTH'(t1_q) + CU_HALF;

  always_ff @(posedge clk_i) begin
    if (en_i.cube) begin
      cu_q    <= cu_d;
      p2_q    <= p2_d;
      t2_q    <= t1_q;
      cmd2_q  <= cmd1_q;
      ctrl2_q <= ctrl1_q;
    end
  end

  assign cmd_o  = cmd2_q;
  assign p1_o   = t2_q;
  assign p2_o   = p2_q;
  assign p3_o   = cu_q[T_FRAC_BITS +: P3_WIDTH];
  assign ctrl_o = ctrl2_q;

endmodule

`default_nettype wire

### rtl/cce_weights.sv
// Weight stage: row [t^3 t^2 t 1] times the doubled basis matrix.
// One register stage. Depends on cce_pkg.
`default_nettype none

module cce_weights import cce_pkg::*; (
  input  wire logic            clk_i,
  input  pipe_en_t             en_i,
  input  wire logic [2:0]      cmd_i,
  input  wire logic [T_WIDTH-1:0]  p1_i,
  input  wire logic [P2_WIDTH-1:0] p2_i,
  input  wire logic [P3_WIDTH-1:0] p3_i,
  input  ctrl_t                ctrl_i [NUM_CTRL],
  output weight_t              w_o    [NUM_CTRL],
  output ctrl_t                ctrl_o [NUM_CTRL]
);

  weight_t w_d [NUM_CTRL];
  weight_t w_q [NUM_CTRL];
  ctrl_t   ctrl_q [NUM_CTRL];

  always_comb begin
    for (int k = 0; k < NUM_CTRL; k++) begin
      w_d[k] = W_WIDTH'(basis_coef(cmd_i, 2'd0, 2'(k))) * $signed(W_WIDTH'(p3_i))
             + W_WIDTH'(basis_coef(cmd_i, 2'd1, 2'(k))) * $signed(W_WIDTH'(p2_i))
             + W_WIDTH'(basis_coef(cmd_i, 2'd2, 2'(k))) * $signed(W_WIDTH'(p1_i))
             + (W_WIDTH'(basis_coef(cmd_i, 2'd3, 2'(k))) <<< T_FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.wt) begin
      w_q    <= w_d;
      ctrl_q <= ctrl_i;
    end
  end

  assign w_o    = w_q;
  assign ctrl_o = ctrl_q;

endmodule

`default_nettype wire

### rtl/cce_mac.sv
// Multiply-accumulate stages: weight times control as two partial products,
// recombine, then sum of four plus rounding offset. Depends on cce_pkg.
`default_nettype none

module cce_mac import cce_pkg::*; (
  input  wire logic clk_i,
  input  pipe_en_t  en_i,
  input  weight_t   w_i    [NUM_CTRL],
  input  ctrl_t     ctrl_i [NUM_CTRL],
  output sum_t      sum_o
);

  localparam int unsigned PL_WIDTH = W_WIDTH + LO_WIDTH + 1;
  localparam int unsigned PH_WIDTH = W_WIDTH + HI_WIDTH;
  localparam sum_t ROUND_OFS = SUM_WIDTH'(1) << T_FRAC_BITS;

  typedef logic signed [PL_WIDTH-1:0]   pl_t;
  typedef logic signed [PH_WIDTH-1:0]   ph_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  pl_t   pl_d [NUM_CTRL];
  pl_t   pl_q [NUM_CTRL];
  ph_t   ph_d [NUM_CTRL];
  ph_t   ph_q [NUM_CTRL];
  prod_t prod_d [NUM_CTRL];
  prod_t prod_q [NUM_CTRL];
  sum_t  sum_d, sum_q;

  // control = hi * 2^LO + lo, lo taken unsigned
  always_comb begin
    for (int k = 0; k < NUM_CTRL; k++) begin
      pl_d[k] = PL_WIDTH'(w_i[k]) *
                $signed({{(PL_WIDTH-LO_WIDTH){1'b0}}, ctrl_i[k][LO_WIDTH-1:0]});
      ph_d[k] = PH_WIDTH'(w_i[k]) * PH_WIDTH'($signed(ctrl_i[k][VALUE_WIDTH-1:LO_WIDTH]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.part) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CTRL; k++) begin
      prod_d[k] = (PROD_WIDTH'(ph_q[k]) <<< LO_WIDTH) + PROD_WIDTH'(pl_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_q <= prod_d;
    end
  end

  assign sum_d = SUM_WIDTH'(prod_q[0]) + SUM_WIDTH'(prod_q[1])
               + SUM_WIDTH'(prod_q[2]) + SUM_WIDTH'(prod_q[3]) + ROUND_OFS;

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

### rtl/cubic_curve_evaluator_unit.sv
// Top level of the cubic curve evaluator: stage control, saturation and
// output register. Depends on cce_pkg, cce_powers, cce_weights, cce_mac.
// Usage:
//   Input channel in_valid_i / in_ready_o / in_data_i carries one curve
//   component per transfer: basis command, parameter t (F fraction bits)
//   and four signed control values. Output channel out_valid_o /
//   out_ready_i / out_data_o returns one rounded, saturated value per input,
//   in order, with a flag set when clipping happened.
//   Unknown commands give zero with the flag clear.
//   Pipeline: an input transfer reaches out_valid_o through seven
//   register stages: t^2, t^3, weights, partial products, product recombine,
//   four-way sum, saturation/output register.
//   Throughput: one transfer per cycle while out_ready_i is high; every
//   stage holds one item.
//   Stalls: each stage loads when it is empty or the stage after it loads,
//   so bubbles are squeezed out and a held output never loses or repeats
//   an item. in_ready_o drops only when all stages are full and the output
//   is held.
//   Reset (rst_ni low, asynchronous): all stage valid bits clear; the
//   pipeline is empty and in_ready_o is high after reset.
`default_nettype none

module cubic_curve_evaluator_unit import cce_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  cce_in_t   in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cce_out_t  out_data_o
);

  localparam int unsigned RES_WIDTH = SUM_WIDTH - T_FRAC_BITS - 1;
  localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] adv;
  pipe_en_t              en;

  // Ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign en = '{sq: adv[0], cube: adv[1], wt: adv[2], part: adv[3],
                prod: adv[4], sum: adv[5], out: adv[6]};

  always_comb begin
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = adv[0];

  // Datapath
  logic [2:0]          cmd_s2;
  logic [T_WIDTH-1:0]  p1_s2;
  logic [P2_WIDTH-1:0] p2_s2;
  logic [P3_WIDTH-1:0] p3_s2;
  ctrl_t               ctrl_s2 [NUM_CTRL];
  weight_t             w_s3    [NUM_CTRL];
  ctrl_t               ctrl_s3 [NUM_CTRL];
  sum_t                sum_s6;

  cce_powers u_powers (
    .clk_i     (clk_i),
    .en_i      (en),
    .in_data_i (in_data_i),
    .cmd_o     (cmd_s2),
    .p1_o      (p1_s2),
    .p2_o      (p2_s2),
    .p3_o      (p3_s2),
    .ctrl_o    (ctrl_s2)
  );

  cce_weights u_weights (
    .clk_i  (clk_i),
    .en_i   (en),
    .cmd_i  (cmd_s2),
    .p1_i   (p1_s2),
    .p2_i   (p2_s2),
    .p3_i   (p3_s2),
    .ctrl_i (ctrl_s2),
    .w_o    (w_s3),
    .ctrl_o (ctrl_s3)
  );

  cce_mac u_mac (
    .clk_i  (clk_i),
    .en_i   (en),
    .w_i    (w_s3),
    .ctrl_i (ctrl_s3),
    .sum_o  (sum_s6)
  );

  // Drop the doubling and F fraction bits: arithmetic shift = floor,
  // with the offset already added this rounds ties toward +inf.
  logic signed [RES_WIDTH-1:0] res;
  logic                        ovf;
  cce_out_t                    out_d, out_q;

  assign res = sum_s6[SUM_WIDTH-1:T_FRAC_BITS+1];
  // fits when all bits above the output sign match it
  assign ovf = !((&res[RES_WIDTH-1:OUT_WIDTH-1]) || !(|res[RES_WIDTH-1:OUT_WIDTH-1]));

  always_comb begin
    out_d.curve_value = res[OUT_WIDTH-1:0];
    out_d.saturated   = 1'b0;
    if (ovf) begin
      out_d.curve_value = res[RES_WIDTH-1] ? OUT_MIN : OUT_MAX;
      out_d.saturated   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign out_data_o  = out_q;

  // Checks
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&vld_q) && !out_ready_i))
    else $error("input blocked while pipeline has room");

  a_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted item not captured in first stage");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |->
      ((out_data_o.curve_value == OUT_MAX) || (out_data_o.curve_value == OUT_MIN)))
    else $error("saturated flag set with value off the limits");

endmodule

`default_nettype wire
